// ===== rtl/rpd_pkg.sv =====
// shared constants, types and the divider step for the raster position decoder
package rpd_pkg;

  localparam int TimeWidth   = 64;
  localparam int WordWidth   = 32;
  localparam int LineWidth   = 16;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = 64;

  localparam int ModSteps  = TimeWidth;
  localparam int LineSteps = WordWidth;
  localparam int PixSteps  = WordWidth;

  localparam logic [WordWidth-1:0] PixelMax = WordWidth'(16'hffff);

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgEnable      = 3'd0,
    CfgPixelPeriod = 3'd1,
    CfgLinePeriod  = 3'd2,
    CfgActiveWidth = 3'd3,
    CfgHsyncWindow = 3'd4,
    CfgVisibleLines = 3'd5,
    CfgTotalLines  = 3'd6,
    CfgVsyncWindow = 3'd7
  } cfg_idx_e;

  // timing settings seen by the flag logic
  typedef struct packed {
    logic [WordWidth-1:0] pix_period;
    logic [WordWidth-1:0] active_width;
    logic [WordWidth-1:0] hs_start;
    logic [WordWidth-1:0] hs_end;
    logic [LineWidth-1:0] visible_lines;
    logic [LineWidth-1:0] vs_start;
    logic [LineWidth-1:0] vs_end;
  } timing_t;

  typedef struct packed {
    logic [LineWidth-1:0] line_index;
    logic [LineWidth-1:0] pixel_index;
    logic                 hsync_on;
    logic                 hblank_on;
    logic                 vsync_on;
    logic                 vblank_on;
    logic                 display_on;
    logic                 timing_valid;
  } result_t;

  // one restoring division step: {quotient bit, new remainder}, needs rem < div
  function automatic logic [WordWidth:0] div_step(input logic [WordWidth-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [WordWidth-1:0] div);
    logic [WordWidth:0] r2;
    logic [WordWidth:0] diff;
    r2   = {rem, bit_in};
    diff = r2 - {1'b0, div};
    if (r2 >= {1'b0, div}) begin
      div_step = {1'b1, diff[WordWidth-1:0]};
    end else begin
      div_step = {1'b0, r2[WordWidth-1:0]};
    end
  endfunction

endpackage

// ===== rtl/rpd_flags.sv =====
// final flag and pixel saturation logic of the raster position decoder
module rpd_flags (
  input  logic                          ok_i,
  input  logic [rpd_pkg::WordWidth-1:0] line_i,
  input  logic [rpd_pkg::WordWidth-1:0] in_line_i,
  input  logic [rpd_pkg::WordWidth-1:0] pix_quo_i,
  input  rpd_pkg::timing_t              timing_i,
  output rpd_pkg::result_t              result_o
);
  import rpd_pkg::*;

  logic [WordWidth-1:0] pixel;
  logic                 hb;
  logic                 vb;

  always_comb begin
    if (timing_i.pix_period == '0) begin
      pixel = '0;
    end else if (pix_quo_i > PixelMax) begin
      pixel = PixelMax;
    end else begin
      pixel = pix_quo_i;
    end
    hb = in_line_i >= timing_i.active_width;
    vb = line_i >= WordWidth'(timing_i.visible_lines);
    result_o = '0;
    if (ok_i) begin
      result_o.line_index   = line_i[LineWidth-1:0];
      result_o.pixel_index  = pixel[LineWidth-1:0];
      result_o.hsync_on     = (in_line_i >= timing_i.hs_start) && (in_line_i < timing_i.hs_end);
      result_o.hblank_on    = hb;
      result_o.vsync_on     = (line_i >= WordWidth'(timing_i.vs_start)) &&
                              (line_i < WordWidth'(timing_i.vs_end));
      result_o.vblank_on    = vb;
      result_o.display_on   = !hb && !vb;
      result_o.timing_valid = 1'b1;
    end
  end

endmodule

// ===== rtl/raster_position_decoder.sv =====
// top level of the raster position decoder: config registers and divider pipeline
// Returns the beam position of a raster for an absolute time in ns. One item
// can be accepted every cycle while the output is not stalled; each item passes
// through the pipeline (64 remainder steps for the time within the frame, 32 quotient steps for
// the line, 32 for the pixel, one flag/output register), one bit per stage.
// The pipeline advances whenever the output register is empty or being taken;
// a stall freezes every stage. The frame length register is updated in the
// cycle of a line period or total lines write, so an item may follow a
// configuration write in the next cycle.
module raster_position_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rpd_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [rpd_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rpd_pkg::TimeWidth-1:0]    sim_time_ns_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rpd_pkg::LineWidth-1:0]    line_index_o,
  output logic [rpd_pkg::LineWidth-1:0]    pixel_index_o,
  output logic                             hsync_on_o,
  output logic                             hblank_on_o,
  output logic                             vsync_on_o,
  output logic                             vblank_on_o,
  output logic                             display_on_o,
  output logic                             timing_valid_o
);
  import rpd_pkg::*;

  // configuration registers
  logic                   enable_q;
  logic [WordWidth-1:0]   pix_period_q;
  logic [WordWidth-1:0]   line_period_q;
  logic [WordWidth-1:0]   active_width_q;
  logic [2*WordWidth-1:0] hsync_window_q;
  logic [LineWidth-1:0]   visible_lines_q;
  logic [LineWidth-1:0]   total_lines_q;
  logic [WordWidth-1:0]   vsync_window_q;
  logic [WordWidth-1:0]   frame_q;
  logic [WordWidth-1:0]   line_period_d;
  logic [LineWidth-1:0]   total_lines_d;
  logic [WordWidth+LineWidth-1:0] frame_prod;
  logic                   cfg_ok;
  timing_t                timing;

  // pipeline stages
  logic                   adv;
  logic                   mod_v_q [ModSteps];
  logic                   mod_ok_q [ModSteps];
  logic [WordWidth-1:0]   mod_rem_q [ModSteps];
  logic [TimeWidth-1:0]   mod_t_q [ModSteps];
  logic [WordWidth-1:0]   mod_rem_d [ModSteps];
  logic                   ln_v_q [LineSteps];
  logic                   ln_ok_q [LineSteps];
  logic [WordWidth-1:0]   ln_rem_q [LineSteps];
  logic [WordWidth-1:0]   ln_dvd_q [LineSteps];
  logic [WordWidth-1:0]   ln_quo_q [LineSteps];
  logic [WordWidth:0]     ln_st [LineSteps];
  logic                   px_v_q [PixSteps];
  logic                   px_ok_q [PixSteps];
  logic [WordWidth-1:0]   px_rem_q [PixSteps];
  logic [WordWidth-1:0]   px_dvd_q [PixSteps];
  logic [WordWidth-1:0]   px_quo_q [PixSteps];
  logic [WordWidth-1:0]   px_line_q [PixSteps];
  logic [WordWidth-1:0]   px_inl_q [PixSteps];
  logic [WordWidth:0]     px_st [PixSteps];
  logic                   out_valid_q;
  result_t                result_d;
  result_t                result_q;

  // new line period / total lines take effect in the frame product at once
  always_comb begin
    line_period_d = line_period_q;
    total_lines_d = total_lines_q;
    if (cfg_we_i && cfg_index_i == CfgLinePeriod) begin
      line_period_d = cfg_data_i[WordWidth-1:0];
    end
    if (cfg_we_i && cfg_index_i == CfgTotalLines) begin
      total_lines_d = cfg_data_i[LineWidth-1:0];
    end
    frame_prod = line_period_d * total_lines_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q        <= 1'b0;
      pix_period_q    <= '0;
      line_period_q   <= '0;
      active_width_q  <= '0;
      hsync_window_q  <= '0;
      visible_lines_q <= '0;
      total_lines_q   <= '0;
      vsync_window_q  <= '0;
      frame_q         <= '0;
    end else begin
      line_period_q <= line_period_d;
      total_lines_q <= total_lines_d;
      frame_q       <= frame_prod[WordWidth-1:0];
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgEnable:       enable_q        <= cfg_data_i[0];
          CfgPixelPeriod:  pix_period_q    <= cfg_data_i[WordWidth-1:0];
          CfgActiveWidth:  active_width_q  <= cfg_data_i[WordWidth-1:0];
          CfgHsyncWindow:  hsync_window_q  <= cfg_data_i;
          CfgVisibleLines: visible_lines_q <= cfg_data_i[LineWidth-1:0];
          CfgVsyncWindow:  vsync_window_q  <= cfg_data_i[WordWidth-1:0];
          default: ;
        endcase
      end
    end
  end

  // timing is usable only when enabled, with a nonzero line period and frame length and a sane vertical setup
  assign cfg_ok = enable_q && (line_period_q != '0) && (frame_q != '0) &&
                  (visible_lines_q != '0) && (vsync_window_q[LineWidth-1:0] != '0) &&
                  (vsync_window_q[WordWidth-1:LineWidth] != '0) &&
                  (visible_lines_q <= total_lines_q);

  assign timing.pix_period    = pix_period_q;
  assign timing.active_width  = active_width_q;
  assign timing.hs_start      = hsync_window_q[WordWidth-1:0];
  assign timing.hs_end        = hsync_window_q[2*WordWidth-1:WordWidth];
  assign timing.visible_lines = visible_lines_q;
  assign timing.vs_start      = vsync_window_q[LineWidth-1:0];
  assign timing.vs_end        = vsync_window_q[WordWidth-1:LineWidth];

  // whole pipeline moves together when the output register can take an item
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // time within frame: remainder of the time by the frame length, msb first
  always_comb begin
    for (int k = 0; k < ModSteps; k++) begin
      if (k == 0) begin
        mod_rem_d[k] = WordWidth'(div_step('0, sim_time_ns_i[TimeWidth-1], frame_q));
      end else begin
        mod_rem_d[k] = WordWidth'(div_step(mod_rem_q[k-1], mod_t_q[k-1][TimeWidth-1],
                                           frame_q));
      end
    end
  end

  // line number and time within line
  always_comb begin
    for (int k = 0; k < LineSteps; k++) begin
      if (k == 0) begin
        ln_st[k] = div_step('0, mod_rem_q[ModSteps-1][WordWidth-1], line_period_q);
      end else begin
        ln_st[k] = div_step(ln_rem_q[k-1], ln_dvd_q[k-1][WordWidth-1], line_period_q);
      end
    end
  end

  // pixel index
  always_comb begin
    for (int k = 0; k < PixSteps; k++) begin
      if (k == 0) begin
        px_st[k] = div_step('0, ln_rem_q[LineSteps-1][WordWidth-1], pix_period_q);
      end else begin
        px_st[k] = div_step(px_rem_q[k-1], px_dvd_q[k-1][WordWidth-1], pix_period_q);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ModSteps; k++) begin
        mod_v_q[k] <= 1'b0;
      end
      for (int k = 0; k < LineSteps; k++) begin
        ln_v_q[k] <= 1'b0;
      end
      for (int k = 0; k < PixSteps; k++) begin
        px_v_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      mod_v_q[0] <= in_valid_i;
      for (int k = 1; k < ModSteps; k++) begin
        mod_v_q[k] <= mod_v_q[k-1];
      end
      ln_v_q[0] <= mod_v_q[ModSteps-1];
      for (int k = 1; k < LineSteps; k++) begin
        ln_v_q[k] <= ln_v_q[k-1];
      end
      px_v_q[0] <= ln_v_q[LineSteps-1];
      for (int k = 1; k < PixSteps; k++) begin
        px_v_q[k] <= px_v_q[k-1];
      end
      out_valid_q <= px_v_q[PixSteps-1];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mod_ok_q[0] <= cfg_ok;
      mod_t_q[0]  <= {sim_time_ns_i[TimeWidth-2:0], 1'b0};
      mod_rem_q[0] <= mod_rem_d[0];
      for (int k = 1; k < ModSteps; k++) begin
        mod_ok_q[k]  <= mod_ok_q[k-1];
        mod_t_q[k]   <= {mod_t_q[k-1][TimeWidth-2:0], 1'b0};
        mod_rem_q[k] <= mod_rem_d[k];
      end

      ln_ok_q[0]  <= mod_ok_q[ModSteps-1];
      ln_dvd_q[0] <= {mod_rem_q[ModSteps-1][WordWidth-2:0], 1'b0};
      ln_rem_q[0] <= ln_st[0][WordWidth-1:0];
      ln_quo_q[0] <= WordWidth'(ln_st[0][WordWidth]);
      for (int k = 1; k < LineSteps; k++) begin
        ln_ok_q[k]  <= ln_ok_q[k-1];
        ln_dvd_q[k] <= {ln_dvd_q[k-1][WordWidth-2:0], 1'b0};
        ln_rem_q[k] <= ln_st[k][WordWidth-1:0];
        ln_quo_q[k] <= {ln_quo_q[k-1][WordWidth-2:0], ln_st[k][WordWidth]};
      end

      px_ok_q[0]   <= ln_ok_q[LineSteps-1];
      px_line_q[0] <= ln_quo_q[LineSteps-1];
      px_inl_q[0]  <= ln_rem_q[LineSteps-1];
      px_dvd_q[0]  <= {ln_rem_q[LineSteps-1][WordWidth-2:0], 1'b0};
      px_rem_q[0]  <= px_st[0][WordWidth-1:0];
      px_quo_q[0]  <= WordWidth'(px_st[0][WordWidth]);
      for (int k = 1; k < PixSteps; k++) begin
        px_ok_q[k]   <= px_ok_q[k-1];
        px_line_q[k] <= px_line_q[k-1];
        px_inl_q[k]  <= px_inl_q[k-1];
        px_dvd_q[k]  <= {px_dvd_q[k-1][WordWidth-2:0], 1'b0};
        px_rem_q[k]  <= px_st[k][WordWidth-1:0];
        px_quo_q[k]  <= {px_quo_q[k-1][WordWidth-2:0], px_st[k][WordWidth]};
      end

      result_q <= result_d;
    end
  end

  // flags and pixel saturation feed the output register
  rpd_flags u_flags (
    .ok_i      (px_ok_q[PixSteps-1]),
    .line_i    (px_line_q[PixSteps-1]),
    .in_line_i (px_inl_q[PixSteps-1]),
    .pix_quo_i (px_quo_q[PixSteps-1]),
    .timing_i  (timing),
    .result_o  (result_d)
  );

  assign out_valid_o    = out_valid_q;
  assign line_index_o   = result_q.line_index;
  assign pixel_index_o  = result_q.pixel_index;
  assign hsync_on_o     = result_q.hsync_on;
  assign hblank_on_o    = result_q.hblank_on;
  assign vsync_on_o     = result_q.vsync_on;
  assign vblank_on_o    = result_q.vblank_on;
  assign display_on_o   = result_q.display_on;
  assign timing_valid_o = result_q.timing_valid;

endmodule

// ===== sim/tb_raster_position_decoder.sv =====
// testbench for the raster position decoder: random timing setups, time queries, scoreboard
`timescale 1ns / 1ps

module tb_raster_position_decoder;
  import rpd_pkg::*;

  // beam position the block should report for one time query
  typedef struct {
    logic [15:0] line_index;
    logic [15:0] pixel_index;
    logic        hsync_on;
    logic        hblank_on;
    logic        vsync_on;
    logic        vblank_on;
    logic        display_on;
    logic        timing_valid;
  } beam_pos_t;

  // register copy plus the queue of pending beam positions
  class beam_scoreboard;
    logic        enable;
    logic [31:0] pix_period, line_period, active_width;
    logic [63:0] hsync_window;
    logic [15:0] visible_lines, total_lines;
    logic [31:0] vsync_window;
    beam_pos_t   pending[$];
    int          errors;

    function void write_reg(cfg_idx_e idx, logic [63:0] data);
      case (idx)
        CfgEnable:       enable = data[0];
        CfgPixelPeriod:  pix_period = data[31:0];
        CfgLinePeriod:   line_period = data[31:0];
        CfgActiveWidth:  active_width = data[31:0];
        CfgHsyncWindow:  hsync_window = data;
        CfgVisibleLines: visible_lines = data[15:0];
        CfgTotalLines:   total_lines = data[15:0];
        CfgVsyncWindow:  vsync_window = data[31:0];
        default: ;
      endcase
    endfunction

    function void note_query(logic [63:0] t);
      beam_pos_t   p;
      logic [31:0] frame, in_frame, line, in_line, pix;
      logic [63:0] prod;
      prod  = 64'(line_period) * 64'(total_lines);
      frame = prod[31:0];
      p = '{default: 1'b0, line_index: 16'd0, pixel_index: 16'd0};
      if (enable && line_period != 0 && frame != 0 && visible_lines != 0 &&
          vsync_window[15:0] != 0 && vsync_window[31:16] != 0 &&
          visible_lines <= total_lines) begin
        in_frame = 32'(t % 64'(frame));
        line     = in_frame / line_period;
        in_line  = in_frame % line_period;
        pix      = (pix_period == 0) ? 32'd0 : in_line / pix_period;
        if (pix > 32'd65535) pix = 32'd65535;
        p.line_index   = line[15:0];
        p.pixel_index  = pix[15:0];
        p.hsync_on     = in_line >= hsync_window[31:0] && in_line < hsync_window[63:32];
        p.hblank_on    = in_line >= active_width;
        p.vsync_on     = line >= 32'(vsync_window[15:0]) && line < 32'(vsync_window[31:16]);
        p.vblank_on    = line >= 32'(visible_lines);
        p.display_on   = !p.hblank_on && !p.vblank_on;
        p.timing_valid = 1'b1;
      end
      pending.push_back(p);
    endfunction

    function void check_result(beam_pos_t got);
      beam_pos_t e;
      if (pending.size() == 0) begin
        $error("result with no query pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.line_index !== e.line_index) begin
        $error("line_index exp %0d got %0d", e.line_index, got.line_index); errors++;
      end
      if (got.pixel_index !== e.pixel_index) begin
        $error("pixel_index exp %0d got %0d", e.pixel_index, got.pixel_index); errors++;
      end
      if (got.hsync_on !== e.hsync_on) begin
        $error("hsync_on exp %0b got %0b", e.hsync_on, got.hsync_on); errors++;
      end
      if (got.hblank_on !== e.hblank_on) begin
        $error("hblank_on exp %0b got %0b", e.hblank_on, got.hblank_on); errors++;
      end
      if (got.vsync_on !== e.vsync_on) begin
        $error("vsync_on exp %0b got %0b", e.vsync_on, got.vsync_on); errors++;
      end
      if (got.vblank_on !== e.vblank_on) begin
        $error("vblank_on exp %0b got %0b", e.vblank_on, got.vblank_on); errors++;
      end
      if (got.display_on !== e.display_on) begin
        $error("display_on exp %0b got %0b", e.display_on, got.display_on); errors++;
      end
      if (got.timing_valid !== e.timing_valid) begin
        $error("timing_valid exp %0b got %0b", e.timing_valid, got.timing_valid); errors++;
      end
    endfunction
  endclass

  localparam int PipeDepth  = 129;
  localparam int CycleLimit = 1000000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [63:0] sim_time_ns_i;
  logic        out_valid_o, out_ready_i;
  logic [15:0] line_index_o, pixel_index_o;
  logic        hsync_on_o, hblank_on_o, vsync_on_o, vblank_on_o, display_on_o;
  logic        timing_valid_o;

  beam_scoreboard sb;
  bit  quiet;        // no idling on either side in the last part of the run
  int  cycles;

  raster_position_decoder u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .sim_time_ns_i,
    .out_valid_o, .out_ready_i,
    .line_index_o, .pixel_index_o, .hsync_on_o, .hblank_on_o,
    .vsync_on_o, .vblank_on_o, .display_on_o, .timing_valid_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle counter doubles as the watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receive side: random stall bursts on out_ready_i, check on each handshake
  initial begin
    int stall;
    beam_pos_t got;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{line_index_o, pixel_index_o, hsync_on_o, hblank_on_o, vsync_on_o,
                vblank_on_o, display_on_o, timing_valid_o};
        sb.check_result(got);
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // one register write, only while nothing is in flight
  task automatic write_cfg(cfg_idx_e idx, logic [63:0] data);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // present one query, hold until accepted; optional idle burst first
  task automatic send_query(logic [63:0] t);
    cfg_we_i <= 1'b0;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sim_time_ns_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_query(t);
  endtask

  // wait for every pending result, then settle so the block is idle
  task automatic drain;
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic setup_timing(logic en, logic [31:0] pix, logic [31:0] line,
                              logic [31:0] act, logic [63:0] hs, logic [15:0] vis,
                              logic [15:0] tot, logic [31:0] vs);
    write_cfg(CfgEnable, 64'(en));
    write_cfg(CfgPixelPeriod, 64'(pix));
    write_cfg(CfgLinePeriod, 64'(line));
    write_cfg(CfgActiveWidth, 64'(act));
    write_cfg(CfgHsyncWindow, hs);
    write_cfg(CfgVisibleLines, 64'(vis));
    write_cfg(CfgTotalLines, 64'(tot));
    write_cfg(CfgVsyncWindow, 64'(vs));
  endtask

  // random but mostly consistent raster, occasionally degenerate
  task automatic random_timing;
    logic [31:0] line, act, pix, hs0, hs1;
    logic [15:0] tot, vis, v0, v1;
    line = (($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1, 5000));
    tot  = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 700));
    vis  = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(1, tot));
    pix  = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 1)) :
           ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 20);
    act  = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, line);
    hs0  = $urandom_range(0, line);
    hs1  = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, line);
    v0   = 16'($urandom_range(($urandom_range(0, 15) == 0) ? 0 : 1, tot));
    v1   = ($urandom_range(0, 15) == 0) ? 16'($urandom()) : 16'($urandom_range(1, tot));
    setup_timing($urandom_range(0, 15) != 0, pix, line, act, {hs1, hs0}, vis, tot,
                 {v1, v0});
  endtask

  function automatic logic [63:0] random_time();
    case ($urandom_range(0, 3))
      0:       return {$urandom(), $urandom()};
      1:       return 64'($urandom_range(0, 5000000));
      2:       return {32'hffff_ffff, $urandom()};
      default: return 64'($urandom());
    endcase
  endfunction

  initial begin
    sb = new();
    sb.write_reg(CfgEnable, 64'd0); sb.write_reg(CfgPixelPeriod, 64'd0);
    sb.write_reg(CfgLinePeriod, 64'd0); sb.write_reg(CfgActiveWidth, 64'd0);
    sb.write_reg(CfgHsyncWindow, 64'd0); sb.write_reg(CfgVisibleLines, 64'd0);
    sb.write_reg(CfgTotalLines, 64'd0); sb.write_reg(CfgVsyncWindow, 64'd0);
    cycles = 0; quiet = 1'b0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_index_i = CfgEnable; cfg_data_i = '0;
    in_valid_i = 1'b0; sim_time_ns_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: block disabled, all outputs zero
    send_query(64'd12345);
    drain();

    // ordinary raster with generous sync windows
    setup_timing(1'b1, 32'd40, 32'd1000, 32'd800, {32'd900, 32'd850}, 16'd480, 16'd525,
                 {16'd492, 16'd490});
    send_query(64'd0);
    send_query(64'hffff_ffff_ffff_ffff);
    send_query(64'd799);
    send_query(64'd800);
    send_query(64'd850);
    send_query(64'd480_000);
    send_query(64'd490_875);
    send_query(64'd524_999);
    send_query(64'd525_000);
    drain();
    // zero pixel period and saturating pixel index
    write_cfg(CfgPixelPeriod, 64'd0);
    send_query(64'd700);
    write_cfg(CfgPixelPeriod, 64'd1);
    write_cfg(CfgLinePeriod, 64'hffff_ffff);
    write_cfg(CfgTotalLines, 64'd1);
    write_cfg(CfgVisibleLines, 64'd1);
    write_cfg(CfgVsyncWindow, 64'h0001_0001);
    send_query(64'd70000);
    send_query(64'hfffffffe);
    drain();
    // frame length wraps to zero: invalid
    setup_timing(1'b1, 32'd1, 32'h1000_0000, 32'd5, {32'd3, 32'd7}, 16'd16, 16'd16,
                 {16'd1, 16'd2});
    send_query(64'd99);
    // visible above total, zero vsync start: invalid; then a valid setup; then disabled: invalid
    setup_timing(1'b1, 32'd3, 32'd100, 32'd50, {32'd20, 32'd10}, 16'd11, 16'd10,
                 {16'd3, 16'd1});
    send_query(64'd99);
    write_cfg(CfgVisibleLines, 64'd5);
    write_cfg(CfgVsyncWindow, 64'h0003_0000);
    send_query(64'd99);
    write_cfg(CfgVsyncWindow, 64'hffff_0001);
    send_query(64'd150);
    write_cfg(CfgEnable, 64'd0);
    send_query(64'd150);
    drain();

    // random phases; each ends drained before the next setup
    for (int ph = 0; ph < 20; ph++) begin
      random_timing();
      if (ph >= 17) quiet = 1'b1;
      for (int n = 0; n < 50; n++) send_query(random_time());
      drain();
    end

    repeat (PipeDepth + 20) @(posedge clk_i);
    if (sb.pending.size() == 0 && sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
